[rtl/fpa_pkg.sv]
// Shared types, opcodes and constants for the fixed-point ALU.
package fpa_pkg;

    localparam int DATA_W        = 32;
    localparam int FRAC_BITS_DEF = 8;

    typedef enum logic [3:0] {
        OP_ADD  = 4'd0,
        OP_SUB  = 4'd1,
        OP_MUL  = 4'd2,
        OP_DIV  = 4'd3,
        OP_LT   = 4'd4,
        OP_LE   = 4'd5,
        OP_GT   = 4'd6,
        OP_GE   = 4'd7,
        OP_EQ   = 4'd8,
        OP_NE   = 4'd9,
        OP_MIN  = 4'd10,
        OP_MAX  = 4'd11,
        OP_INC  = 4'd12,
        OP_DEC  = 4'd13,
        OP_FINT = 4'd14,
        OP_TINT = 4'd15
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_OVF  = 2'd1,
        ST_DIV0 = 2'd2
    } status_t;

    localparam int IN_W  = 72;
    localparam int OUT_W = 40;

endpackage

[rtl/fpa_div.sv]
// Pipelined unsigned divider on magnitudes, one quotient bit per stage.
module fpa_div #(
    parameter int NUM_W = 64,
    parameter int DEN_W = 32
) (
    input  logic             clk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [NUM_W-1:0] quo
);
    // Remainder needs DEN_W+1 bits to hold 2*rem before subtract.
    localparam int REM_W = DEN_W + 1;

    logic [NUM_W-1:0] n_reg   [NUM_W+1];
    logic [NUM_W-1:0] q_reg   [NUM_W+1];
    logic [REM_W-1:0] r_reg   [NUM_W+1];
    logic [DEN_W-1:0] d_reg   [NUM_W+1];

    always_comb
    begin
        n_reg[0] = num;
        q_reg[0] = '0;
        r_reg[0] = '0;
        d_reg[0] = den;
    end

    for (genvar i = 0; i < NUM_W; i++)
    begin : g_stage
        logic [REM_W-1:0] sh;
        logic [REM_W:0]   diff;
        always_comb
        begin
            sh   = {r_reg[i][REM_W-2:0], n_reg[i][NUM_W-1]};
            diff = {1'b0, sh} - {2'b00, d_reg[i]};
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                n_reg[i+1] <= {n_reg[i][NUM_W-2:0], 1'b0};
                d_reg[i+1] <= d_reg[i];
                if (!diff[REM_W])
                begin
                    r_reg[i+1] <= diff[REM_W-1:0];
                    q_reg[i+1] <= {q_reg[i][NUM_W-2:0], 1'b1};
                end
                else
                begin
                    r_reg[i+1] <= sh;
                    q_reg[i+1] <= {q_reg[i][NUM_W-2:0], 1'b0};
                end
            end
        end
    end

    assign quo = q_reg[NUM_W];

endmodule

[rtl/fixed_point_alu_top.sv]
// Top level of the pipelined signed fixed-point ALU.
//
// Usage:
//   Slave channel s_axis_*: tdata = {operand_b, operand_a, command}, one
//   operation per transfer. Master channel m_axis_*: tdata = {status, flag,
//   result}, one transfer per operation, in order.
// Pipeline: 2*DATA_W + 3 stages, set by the bit-per-stage divider that every
//   operation travels beside.
// Throughput: one transfer per cycle in both directions while not stalled.
// Stall: the whole pipeline advances only when its last stage is empty or
//   being taken, so s_axis_tready follows m_axis_tready when full; nothing
//   is lost or repeated.
// Reset: rst_n clears all valid bits at once; the data registers are not
//   reset. No operation is pending after reset.
// Mul: 64-bit product, truncated toward zero on the 2^FRAC_BITS divide.
// Div: (a << FRAC_BITS) / b truncated; b == 0 gives 0 with status 2.
// Overflow on add, sub, mul, div, inc, dec, from_int wraps with status 1.
module fixed_point_alu_top
    import fpa_pkg::*;
#(
    parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // command[3:0], operand_a[35:4], operand_b[67:36], zero pad [71:68]
    input  logic [fpa_pkg::IN_W-1:0]  s_axis_tdata,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // result[31:0], flag[32], status[34:33], zero pad [39:35]
    output logic [fpa_pkg::OUT_W-1:0] m_axis_tdata
);
    localparam int DW    = DATA_W;
    localparam int PW    = 2 * DW;
    localparam int DEPTH = PW + 3;

    typedef struct packed {
        logic [3:0]        op;
        logic [DW-1:0]     a;
        logic [DW-1:0]     b;
        logic [DW-1:0]     res;
        logic              flag;
        logic [1:0]        status;
        logic              neg;
        logic [PW-1:0]     wide;
    } item_t;

    logic              adv;
    logic [DEPTH-1:0]  v_reg;

    assign adv           = !v_reg[DEPTH-1] || m_axis_tready;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = v_reg[DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[DEPTH-2:0], s_axis_tvalid};
    end

    // Stage 1: decode, simple ops, multiplier, divide operand setup.
    logic [3:0]        in_op;
    logic signed [DW-1:0] in_a, in_b;
    assign in_op = s_axis_tdata[3:0];
    assign in_a  = s_axis_tdata[DW+3:4];
    assign in_b  = s_axis_tdata[2*DW+3:DW+4];

    item_t s1_next, s1_reg;
    logic signed [DW:0]   ext;
    logic signed [PW-1:0] shl;
    always_comb
    begin
        s1_next      = '0;
        s1_next.op   = in_op;
        s1_next.a    = in_a;
        s1_next.b    = in_b;
        ext          = '0;
        shl          = PW'(in_a) <<< FRAC_BITS;
        unique case (op_t'(in_op))
            OP_ADD:  ext = {in_a[DW-1], in_a} + {in_b[DW-1], in_b};
            OP_SUB:  ext = {in_a[DW-1], in_a} - {in_b[DW-1], in_b};
            OP_INC:  ext = {in_a[DW-1], in_a} + (DW+1)'(1);
            OP_DEC:  ext = {in_a[DW-1], in_a} - (DW+1)'(1);
            default: ext = '0;
        endcase
        unique case (op_t'(in_op))
            OP_ADD, OP_SUB, OP_INC, OP_DEC:
            begin
                s1_next.res    = ext[DW-1:0];
                s1_next.status = (ext[DW] != ext[DW-1]) ? ST_OVF : ST_OK;
            end
            OP_LT: s1_next.flag = in_a <  in_b;
            OP_LE: s1_next.flag = in_a <= in_b;
            OP_GT: s1_next.flag = in_a >  in_b;
            OP_GE: s1_next.flag = in_a >= in_b;
            OP_EQ: s1_next.flag = in_a == in_b;
            OP_NE: s1_next.flag = in_a != in_b;
            OP_MIN: s1_next.res = (in_a < in_b) ? in_a : in_b;
            OP_MAX: s1_next.res = (in_a > in_b) ? in_a : in_b;
            OP_FINT:
            begin
                s1_next.res    = shl[DW-1:0];
                s1_next.status = (shl != PW'(signed'(shl[DW-1:0]))) ? ST_OVF : ST_OK;
            end
            OP_TINT: s1_next.res = in_a >>> FRAC_BITS;
            OP_MUL:  s1_next.wide = PW'(in_a) * PW'(in_b);
            OP_DIV:
            begin
                s1_next.neg  = in_a[DW-1] ^ in_b[DW-1];
                s1_next.wide = in_a[DW-1] ? -shl : shl;
                if (in_b == '0)
                    s1_next.status = ST_DIV0;
            end
            default: s1_next.res = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            s1_reg <= s1_next;
    end

    // Divider runs beside the item delay line.
    logic [DW-1:0] dmag;
    logic [PW-1:0] quo;
    assign dmag = s1_reg.b[DW-1] ? -s1_reg.b : s1_reg.b;

    fpa_div #(.NUM_W(PW), .DEN_W(DW)) u_div (
        .clk   (clk),
        .en    (adv),
        .num   (s1_reg.wide),
        .den   (dmag),
        .quo   (quo)
    );

    item_t dl_reg [PW+1];
    always_comb dl_reg[0] = s1_reg;
    for (genvar i = 0; i < PW; i++)
    begin : g_dly
        always_ff @(posedge clk)
        begin
            if (adv)
                dl_reg[i+1] <= dl_reg[i];
        end
    end

    // Stage: fix up mul and div.
    item_t           fx_next, fx_reg;
    logic [PW-1:0]   sq, mq;
    logic            neg_p;
    always_comb
    begin
        fx_next = dl_reg[PW];
        neg_p   = fx_next.wide[PW-1];
        mq      = neg_p ? (fx_next.wide + PW'((64'd1 << FRAC_BITS) - 64'd1))
                        : fx_next.wide;
        mq      = PW'(signed'(mq) >>> FRAC_BITS);
        sq      = fx_next.neg ? -quo : quo;
        if (op_t'(fx_next.op) == OP_MUL)
        begin
            fx_next.res    = mq[DW-1:0];
            fx_next.status = (mq != PW'(signed'(mq[DW-1:0]))) ? ST_OVF : ST_OK;
        end
        else if (op_t'(fx_next.op) == OP_DIV && fx_next.status != ST_DIV0)
        begin
            fx_next.res    = sq[DW-1:0];
            fx_next.status = (sq != PW'(signed'(sq[DW-1:0]))) ? ST_OVF : ST_OK;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            fx_reg <= fx_next;
    end

    // Output register.
    logic [OUT_W-1:0] out_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
            out_reg <= {{(OUT_W-DW-3){1'b0}}, fx_reg.status, fx_reg.flag, fx_reg.res};
    end
    assign m_axis_tdata = out_reg;

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed under stall");
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty output");
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[DW+2:DW+1] != 2'd3)
        else $error("bad status code");
    a_flag_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[DW] |-> m_axis_tdata[DW-1:0] == '0)
        else $error("comparison with nonzero result");

endmodule
